### rtl/rau_pkg.sv
// Shared constants, codes and types of the rational arithmetic unit.
`default_nettype none

package rau_pkg;

   // operand width taken from each request field
   localparam int FIELD_WIDTH = 16;
   // width of the request operand ports
   localparam int PORT_W      = 16;
   // width of a product of two operands
   localparam int PROD_W      = 2 * FIELD_WIDTH;
   // working width of the reduction datapath (sum of two products)
   localparam int WORK_W      = PROD_W + 1;
   // shift count of the common power of two
   localparam int SHIFT_W     = $clog2(WORK_W + 1);
   // division step counter
   localparam int CNT_W       = $clog2(WORK_W);
   // result field widths
   localparam int RES_NUM_W   = 33;
   localparam int RES_DEN_W   = 32;

   // request operation codes
   localparam logic [2:0] OP_REDUCE    = 3'd0;
   localparam logic [2:0] OP_ADD       = 3'd1;
   localparam logic [2:0] OP_SUB       = 3'd2;
   localparam logic [2:0] OP_SCALE_NUM = 3'd3;
   localparam logic [2:0] OP_SCALE_DEN = 3'd4;
   localparam logic [2:0] OP_COMPARE   = 3'd5;

   // result status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_NEG  = 2'd1;
   localparam logic [1:0] ST_ZDEN = 2'd2;

   // compare order codes
   localparam logic [1:0] ORD_LESS    = 2'd0;
   localparam logic [1:0] ORD_EQUAL   = 2'd1;
   localparam logic [1:0] ORD_GREATER = 2'd2;

   // status of the shared add/subtract unit
   typedef struct packed {
      logic              ge;    // x >= y
      logic              zero;  // x == y
      logic [WORK_W-1:0] mag;   // x + y, or |x - y|
   } alu_res_type;

endpackage

`default_nettype wire

### rtl/rau_mul.sv
// Registered operand multiplier shared by all product steps.
`default_nettype none

module rau_mul import rau_pkg::*; (
   input  wire logic                   clock,
   input  wire logic [FIELD_WIDTH-1:0] mul_a,
   input  wire logic [FIELD_WIDTH-1:0] mul_b,
   output logic      [PROD_W-1:0]      mul_p
);

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   // form the full product of the selected pair
   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   // register the product for the next step
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;

endmodule

`default_nettype wire

### rtl/rau_alu.sv
// Shared add/subtract/compare unit of the reduction datapath.
`default_nettype none

module rau_alu import rau_pkg::*; (
   input  wire logic [WORK_W-1:0] alu_x,
   input  wire logic [WORK_W-1:0] alu_y,
   input  wire logic              alu_add,
   output alu_res_type            alu_res
);

   logic [WORK_W:0]   sum;
   logic [WORK_W:0]   diff;
   logic [WORK_W-1:0] neg_diff;

   // compute both the sum and the borrowing difference
   always_comb begin
      sum      = {1'b0, alu_x} + {1'b0, alu_y};
      diff     = {1'b0, alu_x} - {1'b0, alu_y};
      neg_diff = (~diff[WORK_W-1:0]) + WORK_W'(1);
   end

   // select the sum or the magnitude of the difference
   always_comb begin
      alu_res.ge   = ~diff[WORK_W];
      alu_res.zero = (diff[WORK_W-1:0] == '0);
      if (alu_add) begin
         alu_res.mag = sum[WORK_W-1:0];
      end else if (~diff[WORK_W]) begin
         alu_res.mag = diff[WORK_W-1:0];
      end else begin
         alu_res.mag = neg_diff;
      end
   end

endmodule

`default_nettype wire

### rtl/rational_arithmetic_unit_top.sv
// Sequence: product and form states S_MUL0, S_MUL1, S_MUL2, S_FORM, where compare, unused codes
// and zero denominators finish; otherwise the common power-of-two strip, binary gcd steps on the
// shared add/subtract unit, then two 33-step restoring divisions (numerator, denominator) on it.
// Throughput: one transaction at a time; busy is high until the strobe cycle; no output stall.
// Reset: synchronous, active high; returns to idle and drops any transaction in flight.
`default_nettype none

module rational_arithmetic_unit_top import rau_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [2:0]           req_type,
   input  wire logic [PORT_W-1:0]    req_a_num,
   input  wire logic [PORT_W-1:0]    req_a_den,
   input  wire logic [PORT_W-1:0]    req_b_num,
   input  wire logic [PORT_W-1:0]    req_b_den,
   input  wire logic [PORT_W-1:0]    req_scale,
   output logic                      rsp_strobe,
   output logic [RES_NUM_W-1:0]      rsp_res_num,
   output logic [RES_DEN_W-1:0]      rsp_res_den,
   output logic [1:0]                rsp_status,
   output logic [1:0]                rsp_order
);

   // sequencer states
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MUL0 = 4'd1;
   localparam logic [3:0] S_MUL1 = 4'd2;
   localparam logic [3:0] S_MUL2 = 4'd3;
   localparam logic [3:0] S_FORM = 4'd4;
   localparam logic [3:0] S_TWOS = 4'd5;
   localparam logic [3:0] S_GCD  = 4'd6;
   localparam logic [3:0] S_DIVN = 4'd7;
   localparam logic [3:0] S_DIVD = 4'd8;

   logic [3:0]             state_ff, state_in;
   logic [2:0]             op_ff, op_in;
   logic [FIELD_WIDTH-1:0] an_ff, an_in;
   logic [FIELD_WIDTH-1:0] ad_ff, ad_in;
   logic [FIELD_WIDTH-1:0] bn_ff, bn_in;
   logic [FIELD_WIDTH-1:0] bd_ff, bd_in;
   logic [FIELD_WIDTH-1:0] sc_ff, sc_in;
   logic [PROD_W-1:0]      p0_ff, p0_in;
   logic [PROD_W-1:0]      p1_ff, p1_in;
   logic [WORK_W-1:0]      num_ff, num_in;
   logic [WORK_W-1:0]      den_ff, den_in;
   logic [WORK_W-1:0]      u_ff, u_in;
   logic [WORK_W-1:0]      v_ff, v_in;
   logic [WORK_W-1:0]      g_ff, g_in;
   logic [WORK_W-1:0]      rem_ff, rem_in;
   logic [WORK_W-1:0]      quo_ff, quo_in;
   logic [SHIFT_W-1:0]     k_ff, k_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   neg_ff, neg_in;
   logic                   strobe_ff, strobe_in;
   logic [RES_NUM_W-1:0]   res_num_ff, res_num_in;
   logic [RES_DEN_W-1:0]   res_den_ff, res_den_in;
   logic [1:0]             status_ff, status_in;
   logic [1:0]             order_ff, order_in;

   logic [FIELD_WIDTH-1:0] mul_a;
   logic [FIELD_WIDTH-1:0] mul_b;
   logic [PROD_W-1:0]      mul_p;
   logic [WORK_W-1:0]      alu_x;
   logic [WORK_W-1:0]      alu_y;
   logic                   alu_add;
   alu_res_type            alu_res;
   logic [WORK_W-1:0]      trial;
   logic [WORK_W-1:0]      form_num;
   logic [WORK_W-1:0]      form_den;
   logic [WORK_W-1:0]      quo_next;

   rau_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   rau_alu u_alu (
      .alu_x   (alu_x),
      .alu_y   (alu_y),
      .alu_add (alu_add),
      .alu_res (alu_res)
   );

   // pick the multiplier pair of each product step
   always_comb begin
      case (state_ff)
         S_MUL0: begin
            mul_a = an_ff;
            mul_b = bd_ff;
         end
         S_MUL1: begin
            mul_a = bn_ff;
            mul_b = ad_ff;
         end
         default: begin
            if (op_ff == OP_SCALE_NUM) begin
               mul_a = an_ff;
               mul_b = sc_ff;
            end else if (op_ff == OP_SCALE_DEN) begin
               mul_a = ad_ff;
               mul_b = sc_ff;
            end else begin
               mul_a = ad_ff;
               mul_b = bd_ff;
            end
         end
      endcase
   end

   // next restoring-division partial remainder
   assign trial    = {rem_ff[WORK_W-2:0], quo_ff[WORK_W-1]};
   assign quo_next = {quo_ff[WORK_W-2:0], alu_res.ge};

   // steer the shared add/subtract unit
   always_comb begin
      alu_add = 1'b0;
      case (state_ff)
         S_GCD: begin
            alu_x = u_ff;
            alu_y = v_ff;
         end
         S_DIVN, S_DIVD: begin
            alu_x = trial;
            alu_y = g_ff;
         end
         default: begin
            alu_x   = WORK_W'(p0_ff);
            alu_y   = WORK_W'(p1_ff);
            alu_add = (op_ff == OP_ADD);
         end
      endcase
   end

   // form the fraction to be reduced
   always_comb begin
      case (op_ff)
         OP_ADD, OP_SUB: begin
            form_num = alu_res.mag;
            form_den = WORK_W'(mul_p);
         end
         OP_SCALE_NUM: begin
            form_num = WORK_W'(mul_p);
            form_den = WORK_W'(ad_ff);
         end
         OP_SCALE_DEN: begin
            form_num = WORK_W'(an_ff);
            form_den = WORK_W'(mul_p);
         end
         default: begin
            form_num = WORK_W'(an_ff);
            form_den = WORK_W'(ad_ff);
         end
      endcase
   end

   // sequence one transaction through products, gcd and divisions
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      an_in      = an_ff;
      ad_in      = ad_ff;
      bn_in      = bn_ff;
      bd_in      = bd_ff;
      sc_in      = sc_ff;
      p0_in      = p0_ff;
      p1_in      = p1_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      u_in       = u_ff;
      v_in       = v_ff;
      g_in       = g_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      k_in       = k_ff;
      cnt_in     = cnt_ff;
      neg_in     = neg_ff;
      strobe_in  = 1'b0;
      res_num_in = res_num_ff;
      res_den_in = res_den_ff;
      status_in  = status_ff;
      order_in   = order_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_type;
               an_in    = FIELD_WIDTH'(req_a_num);
               ad_in    = FIELD_WIDTH'(req_a_den);
               bn_in    = FIELD_WIDTH'(req_b_num);
               bd_in    = FIELD_WIDTH'(req_b_den);
               sc_in    = FIELD_WIDTH'(req_scale);
               state_in = S_MUL0;
            end
         end
         S_MUL0: begin
            state_in = S_MUL1;
         end
         S_MUL1: begin
            p0_in    = mul_p;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            p1_in    = mul_p;
            state_in = S_FORM;
         end
         S_FORM: begin
            res_num_in = '0;
            res_den_in = '0;
            status_in  = ST_OK;
            order_in   = ORD_LESS;
            neg_in     = (op_ff == OP_SUB) && !alu_res.ge;
            if (op_ff == OP_COMPARE) begin
               // finish the compare directly from the cross products
               strobe_in = 1'b1;
               state_in  = S_IDLE;
               if (ad_ff == '0 || bd_ff == '0) begin
                  status_in = ST_ZDEN;
                  order_in  = ORD_EQUAL;
               end else if (!alu_res.ge) begin
                  order_in = ORD_LESS;
               end else if (alu_res.zero) begin
                  order_in = ORD_EQUAL;
               end else begin
                  order_in = ORD_GREATER;
               end
            end else if (op_ff > OP_COMPARE) begin
               // drop unused codes with an all-zero result
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else if (form_den == '0) begin
               strobe_in = 1'b1;
               status_in = ST_ZDEN;
               state_in  = S_IDLE;
            end else begin
               num_in   = form_num;
               den_in   = form_den;
               u_in     = form_num;
               v_in     = form_den;
               k_in     = '0;
               state_in = S_TWOS;
            end
         end
         S_TWOS: begin
            // strip the power of two common to both terms
            if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + SHIFT_W'(1);
            end else begin
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (u_ff == '0) begin
               g_in     = v_ff << k_ff;
               quo_in   = num_ff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = S_DIVN;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (alu_res.ge) begin
               u_in = alu_res.mag >> 1;
            end else begin
               v_in = alu_res.mag >> 1;
            end
         end
         S_DIVN, S_DIVD: begin
            // one restoring division step per cycle
            rem_in = alu_res.ge ? alu_res.mag : trial;
            quo_in = quo_next;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(WORK_W - 1)) begin
               rem_in = '0;
               cnt_in = '0;
               if (state_ff == S_DIVN) begin
                  num_in   = quo_next;
                  quo_in   = den_ff;
                  state_in = S_DIVD;
               end else begin
                  res_num_in = RES_NUM_W'(num_ff);
                  res_den_in = RES_DEN_W'(quo_next);
                  status_in  = neg_ff ? ST_NEG : ST_OK;
                  order_in   = ORD_LESS;
                  strobe_in  = 1'b1;
                  state_in   = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   // advance the datapath registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      an_ff      <= an_in;
      ad_ff      <= ad_in;
      bn_ff      <= bn_in;
      bd_ff      <= bd_in;
      sc_ff      <= sc_in;
      p0_ff      <= p0_in;
      p1_ff      <= p1_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      u_ff       <= u_in;
      v_ff       <= v_in;
      g_ff       <= g_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      k_ff       <= k_in;
      cnt_ff     <= cnt_in;
      neg_ff     <= neg_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      status_ff  <= status_in;
      order_ff   <= order_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_strobe  = strobe_ff;
   assign rsp_res_num = res_num_ff;
   assign rsp_res_den = res_den_ff;
   assign rsp_status  = status_ff;
   assign rsp_order   = order_ff;

   // a result follows only a transaction in flight
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a transaction in flight");

   // an accepted transaction makes the unit busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // a zero-denominator result carries an all-zero fraction
   a_zden_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_ZDEN) |-> (rsp_res_num == '0 && rsp_res_den == '0))
      else $error("zero-denominator result with nonzero fraction");

   // the gcd loop never runs on a zero divisor term
   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GCD) |-> (v_ff != '0))
      else $error("gcd term reached zero");

endmodule

`default_nettype wire

### tb/tb_rational_arithmetic_unit_top.sv
// Self-checking testbench of the rational arithmetic unit: directed and random fraction requests.
`timescale 1ns / 1ps

module tb_rational_arithmetic_unit_top import rau_pkg::*; ();

   localparam int  CYCLE_LIMIT   = 1_500_000;
   localparam int  DRAIN_CYCLES  = 250;
   localparam int  RANDOM_ITEMS  = 1550;

   // request codes with no operation behind them
   localparam logic [2:0] OP_UNUSED_LO = 3'd6;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   // one expected or observed result
   typedef struct packed {
      logic [RES_NUM_W-1:0] num;
      logic [RES_DEN_W-1:0] den;
      logic [1:0]           status;
      logic [1:0]           order;
   } fraction_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [2:0]           req_type  = '0;
   logic [PORT_W-1:0]    req_a_num = '0;
   logic [PORT_W-1:0]    req_a_den = '0;
   logic [PORT_W-1:0]    req_b_num = '0;
   logic [PORT_W-1:0]    req_b_den = '0;
   logic [PORT_W-1:0]    req_scale = '0;
   logic                 rsp_strobe;
   logic [RES_NUM_W-1:0] rsp_res_num;
   logic [RES_DEN_W-1:0] rsp_res_den;
   logic [1:0]           rsp_status;
   logic [1:0]           rsp_order;

   fraction_result_type pending_fractions[$];
   bit                  sender_idles = 1'b1;
   int                  error_count = 0;
   int                  results_checked = 0;
   int                  sent_count = 0;
   int                  op_sent[8];
   int                  cycle_count = 0;

   rational_arithmetic_unit_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_type   (req_type),
      .req_a_num  (req_a_num),
      .req_a_den  (req_a_den),
      .req_b_num  (req_b_num),
      .req_b_den  (req_b_den),
      .req_scale  (req_scale),
      .rsp_strobe (rsp_strobe),
      .rsp_res_num(rsp_res_num),
      .rsp_res_den(rsp_res_den),
      .rsp_status (rsp_status),
      .rsp_order  (rsp_order)
   );

   // clock: 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Euclid on 64-bit magnitudes
   function automatic longint unsigned common_divisor(longint unsigned p, longint unsigned q);
      longint unsigned r;
      while (q != 0) begin
         r = p % q;
         p = q;
         q = r;
      end
      return p;
   endfunction

   // bring num/den to lowest terms; a zero denominator overrides the given status
   function automatic fraction_result_type lowest_terms(longint unsigned num,
                                                        longint unsigned den,
                                                        logic [1:0] st);
      fraction_result_type r;
      longint unsigned     g;
      r = '0;
      if (den == 0) begin
         r.status = ST_ZDEN;
      end else begin
         g        = common_divisor(num, den);
         r.num    = RES_NUM_W'(num / g);
         r.den    = RES_DEN_W'(den / g);
         r.status = st;
      end
      return r;
   endfunction

   // expected result of one request
   function automatic fraction_result_type predict_fraction(logic [2:0] op,
                                                            logic [PORT_W-1:0] an_in,
                                                            logic [PORT_W-1:0] ad_in,
                                                            logic [PORT_W-1:0] bn_in,
                                                            logic [PORT_W-1:0] bd_in,
                                                            logic [PORT_W-1:0] sc_in);
      longint unsigned     mask, an, ad, bn, bd, sc, cross_a, cross_b;
      fraction_result_type r;
      mask    = (64'd1 << FIELD_WIDTH) - 64'd1;
      an      = 64'(an_in) & mask;
      ad      = 64'(ad_in) & mask;
      bn      = 64'(bn_in) & mask;
      bd      = 64'(bd_in) & mask;
      sc      = 64'(sc_in) & mask;
      cross_a = an * bd;
      cross_b = bn * ad;
      r       = '0;
      case (op)
         OP_REDUCE:    r = lowest_terms(an, ad, ST_OK);
         OP_ADD:       r = lowest_terms(cross_a + cross_b, ad * bd, ST_OK);
         OP_SUB: begin
            if (cross_a >= cross_b) r = lowest_terms(cross_a - cross_b, ad * bd, ST_OK);
            else                    r = lowest_terms(cross_b - cross_a, ad * bd, ST_NEG);
         end
         OP_SCALE_NUM: r = lowest_terms(an * sc, ad, ST_OK);
         OP_SCALE_DEN: r = lowest_terms(an, ad * sc, ST_OK);
         OP_COMPARE: begin
            if (ad == 0 || bd == 0) begin
               r.status = ST_ZDEN;
               r.order  = ORD_EQUAL;
            end else if (cross_a < cross_b) begin
               r.order = ORD_LESS;
            end else if (cross_a == cross_b) begin
               r.order = ORD_EQUAL;
            end else begin
               r.order = ORD_GREATER;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // drive one request, hold it until accepted, then queue its expected result
   task automatic send_request(logic [2:0] op, logic [PORT_W-1:0] an, logic [PORT_W-1:0] ad,
                               logic [PORT_W-1:0] bn, logic [PORT_W-1:0] bd,
                               logic [PORT_W-1:0] sc);
      int gap;
      if (sender_idles && $urandom_range(0, 99) < 32) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_type  <= op;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      req_scale <= sc;
      do @(posedge clock); while (busy !== 1'b0);
      pending_fractions.push_back(predict_fraction(op, an, ad, bn, bd, sc));
      sent_count++;
      op_sent[op]++;
   endtask

   // hold off the sender until every outstanding result has come back
   task automatic wait_for_drain();
      start <= 1'b0;
      while (pending_fractions.size() != 0) @(posedge clock);
   endtask

   // operand biased toward zero, all ones, powers of two and small values
   function automatic logic [PORT_W-1:0] pick_operand();
      logic [31:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return PORT_W'(1) << $urandom_range(0, PORT_W - 1);
         3, 4, 5: return PORT_W'($urandom_range(1, 24));
         6:       return PORT_W'($urandom_range(1, 255) << $urandom_range(0, 8));
         default: return raw[PORT_W-1:0];
      endcase
   endfunction

   // denominator: zero only now and then
   function automatic logic [PORT_W-1:0] pick_divisor();
      logic [PORT_W-1:0] v;
      if ($urandom_range(0, 24) == 0) return '0;
      v = pick_operand();
      return (v == '0) ? PORT_W'(1) : v;
   endfunction

   task automatic test_reduce_directed();
      send_request(OP_REDUCE, 16'd6, 16'd4, '0, '0, '0);
      send_request(OP_REDUCE, 16'd0, 16'd5, '0, '0, '0);       // zero numerator
      send_request(OP_REDUCE, 16'd5, 16'd0, '0, '0, '0);       // zero denominator
      send_request(OP_REDUCE, 16'hFFFF, 16'hFFFF, '1, '1, '1);
      send_request(OP_REDUCE, 16'h8000, 16'h4000, '0, '0, '0);
   endtask

   task automatic test_add_sub_directed();
      send_request(OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3, '0);
      send_request(OP_ADD, 16'hFFFF, 16'd1, 16'hFFFF, 16'd1, '0);
      send_request(OP_ADD, 16'hFFFF, 16'hFFFE, 16'hFFFE, 16'hFFFF, '0);
      send_request(OP_ADD, 16'd3, 16'd0, 16'd1, 16'd7, '0);
      send_request(OP_SUB, 16'd1, 16'd2, 16'd1, 16'd3, '0);
      send_request(OP_SUB, 16'd1, 16'd3, 16'd1, 16'd2, '0);    // negative difference
      send_request(OP_SUB, 16'd2, 16'd4, 16'd1, 16'd2, '0);    // zero difference
      send_request(OP_SUB, 16'd1, 16'd0, 16'd5, 16'd3, '0);    // zero denominator
   endtask

   task automatic test_scale_directed();
      send_request(OP_SCALE_NUM, 16'hFFFF, 16'd1, '0, '0, 16'hFFFF);
      send_request(OP_SCALE_NUM, 16'd7, 16'd9, '0, '0, 16'd0);
      send_request(OP_SCALE_NUM, 16'd7, 16'd0, '0, '0, 16'd3);
      send_request(OP_SCALE_DEN, 16'd3, 16'd4, '0, '0, 16'd0);
      send_request(OP_SCALE_DEN, 16'd3, 16'd4, '0, '0, 16'hFFFF);
   endtask

   task automatic test_compare_directed();
      send_request(OP_COMPARE, 16'd1, 16'd3, 16'd1, 16'd2, '0);
      send_request(OP_COMPARE, 16'd1, 16'd2, 16'd2, 16'd4, '0);
      send_request(OP_COMPARE, 16'hFFFF, 16'd1, 16'd1, 16'hFFFF, '0);
      send_request(OP_COMPARE, 16'd1, 16'd0, 16'd1, 16'd2, '0);
      send_request(OP_COMPARE, 16'd1, 16'd2, 16'd1, 16'd0, '0);
   endtask

   task automatic test_unused_codes();
      send_request(OP_UNUSED_LO, '1, '1, '1, '1, '1);
      send_request(OP_UNUSED_HI, 16'd5, 16'd3, 16'd2, 16'd9, 16'd4);
   endtask

   // random requests, mostly valid operations, a few unused codes
   task automatic test_random_traffic(int count);
      logic [2:0] op;
      repeat (count) begin
         if ($urandom_range(0, 99) < 4) op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
         else                           op = 3'($urandom_range(OP_REDUCE, OP_COMPARE));
         send_request(op, pick_operand(), pick_divisor(), pick_operand(), pick_divisor(),
                      pick_operand());
      end
   endtask

   // pause the sender with nothing in flight, then resume
   task automatic test_pause_until_drained();
      wait_for_drain();
      test_random_traffic(20);
   endtask

   // compare one field and report a mismatch
   function automatic void check_field(string label, logic [63:0] expected, logic [63:0] actual);
      if (expected !== actual) begin
         error_count++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, label,
                  expected, actual);
      end
   endfunction

   // check each strobed result against the oldest expectation
   always @(posedge clock) begin
      fraction_result_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_fractions.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, actual num 0x%0h den 0x%0h",
                     $time, rsp_res_num, rsp_res_den);
         end else begin
            want = pending_fractions.pop_front();
            results_checked++;
            check_field("res_num", 64'(want.num),    64'(rsp_res_num));
            check_field("res_den", 64'(want.den),    64'(rsp_res_den));
            check_field("status",  64'(want.status), 64'(rsp_status));
            check_field("order",   64'(want.order),  64'(rsp_order));
         end
      end
   end

   // end the run if it hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_fractions.size());
         $display("tb_rational_arithmetic_unit_top: FAIL");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reduce_directed();
      test_add_sub_directed();
      test_scale_directed();
      test_compare_directed();
      test_unused_codes();
      test_random_traffic(RANDOM_ITEMS * 6 / 10);
      // long stretch without sender gaps
      sender_idles = 1'b0;
      test_random_traffic(RANDOM_ITEMS * 2 / 10);
      sender_idles = 1'b1;
      test_pause_until_drained();
      test_random_traffic(RANDOM_ITEMS * 2 / 10);

      // let everything come back, then watch for strays
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_fractions.size() != 0) begin
         error_count++;
         $display("%0t: %0d expected results never arrived", $time, pending_fractions.size());
      end

      $display("Sent %0d requests: reduce %0d, add %0d, sub %0d, scale num %0d, scale den %0d,",
               sent_count, op_sent[OP_REDUCE], op_sent[OP_ADD], op_sent[OP_SUB],
               op_sent[OP_SCALE_NUM], op_sent[OP_SCALE_DEN]);
      $display("compare %0d, unused codes %0d; %0d results checked, %0d errors",
               op_sent[OP_COMPARE], op_sent[OP_UNUSED_LO] + op_sent[OP_UNUSED_HI],
               results_checked, error_count);
      if (error_count == 0) begin
         $display("tb_rational_arithmetic_unit_top: PASS");
      end else begin
         $display("tb_rational_arithmetic_unit_top: FAIL");
      end
      $finish;
   end

endmodule
